### src/bsl_pkg.sv
// Shared types, token codes and character tables for the byte stream lexer.
// No dependencies.
package bsl_pkg;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } bsl_req_type;

   typedef struct packed {
      logic [5:0] token_kind;
      logic [7:0] text_char;
      logic       last_of_token;
   } bsl_rsp_type;

   typedef enum logic [2:0] {
      MODE_TEXT    = 3'b001,
      MODE_COMMENT = 3'b010,
      MODE_STAR    = 3'b100
   } bsl_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } bsl_state_type;

   localparam int          NUM_KEYWORDS  = 11;
   localparam logic [5:0]  TOK_IDENT     = 6'd12;
   localparam logic [5:0]  TOK_NUMBER    = 6'd13;
   localparam logic [5:0]  TOK_CMT_OPEN  = 6'd56;
   localparam logic [5:0]  TOK_CMT_CLOSE = 6'd57;
   localparam logic [5:0]  TOK_UNCLOSED  = 6'd58;
   localparam logic [5:0]  TOK_TOO_LONG  = 6'd59;
   localparam logic [5:0]  TOK_NONE      = 6'd0;

   localparam logic [7:0]  CH_NUL   = 8'h00;
   localparam logic [7:0]  CH_TAB   = 8'h09;
   localparam logic [7:0]  CH_LF    = 8'h0a;
   localparam logic [7:0]  CH_CR    = 8'h0d;
   localparam logic [7:0]  CH_SPACE = 8'h20;
   localparam logic [7:0]  CH_STAR  = 8'h2a;
   localparam logic [7:0]  CH_SLASH = 8'h2f;
   localparam logic [5:0]  WORD_CAP = 6'd32;

   function automatic logic [5:0] delim_code(input logic [7:0] b);
      logic [5:0] r;
      unique case (b)
         "+":     r = 6'd14;
         "-":     r = 6'd15;
         "*":     r = 6'd16;
         ";":     r = 6'd17;
         "(":     r = 6'd18;
         ")":     r = 6'd19;
         "=":     r = 6'd20;
         ">":     r = 6'd21;
         "<":     r = 6'd23;
         ":":     r = 6'd26;
         "/":     r = 6'd28;
         "!":     r = 6'd30;
         "{":     r = 6'd31;
         "}":     r = 6'd32;
         "&":     r = 6'd33;
         "|":     r = 6'd34;
         CH_LF:   r = 6'd35;
         default: r = TOK_NONE;
      endcase
      return r;
   endfunction

   function automatic logic can_pair(input logic [7:0] b);
      return b == ">" || b == "<" || b == ":" || b == "+" || b == "-" ||
             b == "*" || b == "/" || b == "&" || b == "|" || b == "!";
   endfunction

   function automatic logic [5:0] pair_code(input logic [7:0] h, input logic [7:0] b);
      logic [5:0] r;
      priority if (h == ">" && b == "=") r = 6'd41;
      else if (h == "<" && b == "=") r = 6'd42;
      else if (h == "<" && b == ">") r = 6'd43;
      else if (h == ":" && b == "=") r = 6'd44;
      else if (h == "+" && b == "=") r = 6'd45;
      else if (h == "+" && b == "+") r = 6'd46;
      else if (h == "-" && b == "=") r = 6'd47;
      else if (h == "-" && b == "-") r = 6'd48;
      else if (h == "*" && b == "=") r = 6'd49;
      else if (h == "/" && b == "=") r = 6'd50;
      else if (h == "&" && b == "&") r = 6'd51;
      else if (h == "|" && b == "|") r = 6'd52;
      else if (h == ">" && b == ">") r = 6'd53;
      else if (h == "<" && b == "<") r = 6'd54;
      else if (h == "!" && b == "=") r = 6'd55;
      else r = TOK_NONE;
      return r;
   endfunction

   // Keyword text, first character in the low byte.
   function automatic logic [63:0] kw_text(input int k);
      logic [63:0] r;
      unique case (k)
         0:       r = {16'h0, 8'h0, 8'h0, "d", "i", "o", "v"};
         1:       r = {40'h0, "t", "n", "i"};
         2:       r = {24'h0, "t", "a", "o", "l", "f"};
         3:       r = {16'h0, "e", "l", "b", "u", "o", "d"};
         4:       r = {48'h0, "f", "i"};
         5:       r = {32'h0, "e", "s", "l", "e"};
         6:       r = {40'h0, "r", "o", "f"};
         7:       r = {48'h0, "o", "d"};
         8:       r = {24'h0, "e", "l", "i", "h", "w"};
         9:       r = {16'h0, "n", "r", "u", "t", "e", "r"};
         10:      r = {24'h0, "k", "a", "e", "r", "b"};
         default: r = 64'h0;
      endcase
      return r;
   endfunction

   // One character of a keyword, by position within the keyword.
   function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
      logic [63:0] t;
      t = kw_text(k);
      return t[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [2:0] kw_len(input int k);
      logic [2:0] r;
      unique case (k)
         0, 5:       r = 3'd4;
         1, 6:       r = 3'd3;
         2, 8, 10:   r = 3'd5;
         3, 9:       r = 3'd6;
         4, 7:       r = 3'd2;
         default:    r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

### src/bsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

### src/byte_stream_lexer_unit.sv
// Byte stream lexer top level: byte-serial tokenizer with the word held in a RAM.
// Depends on bsl_pkg and bsl_ram.
//
// Usage: one source byte per transfer on the req_ channel (valid/stall).
// Tokens leave on the rsp_ channel, one result per transfer; a word token
// below the length limit is a run of results, one per lowercased character,
// last_of_token on the final one. Every other token is a single result.
// csr_write_enable/csr_write_data set the word length limit (reset 32);
// write it only while the block is idle.
// Throughput: one item at a time. A byte that yields nothing is accepted,
// then retired; each single-result token is put into the output register
// before retiring, and each word character is first read from the word RAM
// (registered read data) before it enters the output register.
// Reset: synchronous, clears the stream state, the limit and the output
// valid flag; the word RAM needs no clearing, as only entries written for the
// current word are read.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; req_stall stays high until the item's last result is
// in the output register and its work has retired.
module byte_stream_lexer_unit #(
   parameter int WORD_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsl_pkg::bsl_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bsl_pkg::bsl_rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [5:0]           csr_write_data
);
   import bsl_pkg::*;

   localparam int         AW    = $clog2(WORD_DEPTH);
   localparam logic [6:0] DEPTH7 = 7'(WORD_DEPTH);
   localparam logic [6:0] CAP7   = (WORD_DEPTH < 32) ? 7'(WORD_DEPTH) : 7'(WORD_CAP);

   bsl_state_type     state_ff, state_in;
   bsl_mode_type      mode_ff, mode_in;
   logic [5:0]        limit_ff;
   logic [5:0]        count_ff, count_in;
   logic              digits_ff, digits_in;
   logic [NUM_KEYWORDS-1:0] match_ff, match_in;
   logic [7:0]        held_ff, held_in;

   // pending work of the accepted item
   logic              pre_ff, pre_in;
   logic [5:0]        pre_kind_ff, pre_kind_in;
   logic              word_ff, word_in;
   logic              long_ff, long_in;
   logic [5:0]        word_kind_ff, word_kind_in;
   logic [5:0]        word_len_ff, word_len_in;
   logic [5:0]        idx_ff, idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              post_ff, post_in;
   logic [5:0]        post_kind_ff, post_kind_in;

   logic              rsp_valid_ff, rsp_valid_in;
   bsl_rsp_type       rsp_data_ff, rsp_data_in;

   logic              accept, slot_free;
   logic [7:0]        b, lower;
   logic [5:0]        d_code, p_code, word_code;
   logic              is_word_char;
   logic [6:0]        lim7;
   logic              ram_we, ram_re;
   logic [7:0]        ram_rd;
   logic [5:0]        idx_next;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign b      = req_payload.source_byte;
   assign lower  = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   assign d_code = delim_code(b);
   assign p_code = pair_code(held_ff, b);
   assign is_word_char = d_code == TOK_NONE && b != CH_SPACE && b != CH_TAB &&
                         b != CH_CR && b != CH_NUL;
   assign lim7 = ({1'b0, limit_ff} > CAP7) ? CAP7 : {1'b0, limit_ff};
   assign idx_next = idx_ff + 6'd1;

   always_comb begin
      word_code = TOK_IDENT;
      if (digits_ff) begin
         word_code = TOK_NUMBER;
      end else begin
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (match_ff[k] && count_ff == {3'b0, kw_len(k)}) begin
               word_code = 6'(k + 1);
            end
         end
      end
   end

   bsl_ram #(.WIDTH(8), .DEPTH(WORD_DEPTH)) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (lower),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      digits_in    = digits_ff;
      match_in     = match_ff;
      held_in      = held_ff;
      pre_in       = pre_ff;
      pre_kind_in  = pre_kind_ff;
      word_in      = word_ff;
      long_in      = long_ff;
      word_kind_in = word_kind_ff;
      word_len_in  = word_len_ff;
      idx_in       = idx_ff;
      rd_pend_in   = rd_pend_ff;
      post_in      = post_ff;
      post_kind_in = post_kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_BUSY;
               pre_in       = 1'b0;
               post_in      = 1'b0;
               word_in      = 1'b0;
               idx_in       = '0;
               rd_pend_in   = 1'b0;
               long_in      = {1'b0, count_ff} >= lim7;
               word_kind_in = word_code;
               word_len_in  = count_ff;
               if (req_payload.end_of_input) begin
                  word_in   = count_ff != '0;
                  count_in  = '0;
                  digits_in = 1'b1;
                  match_in  = '1;
                  held_in   = '0;
                  mode_in   = MODE_TEXT;
                  if (held_ff != '0) begin
                     post_in      = 1'b1;
                     post_kind_in = delim_code(held_ff);
                  end else if (mode_ff != MODE_TEXT) begin
                     post_in      = 1'b1;
                     post_kind_in = TOK_UNCLOSED;
                  end
               end else if (mode_ff != MODE_TEXT) begin
                  if (mode_ff == MODE_STAR && b == CH_SLASH) begin
                     post_in      = 1'b1;
                     post_kind_in = TOK_CMT_CLOSE;
                     mode_in      = MODE_TEXT;
                  end else begin
                     mode_in = (b == CH_STAR) ? MODE_STAR : MODE_COMMENT;
                  end
               end else if (held_ff == CH_SLASH && b == CH_STAR) begin
                  post_in      = 1'b1;
                  post_kind_in = TOK_CMT_OPEN;
                  held_in      = '0;
                  mode_in      = MODE_COMMENT;
               end else if (held_ff != '0 && p_code != TOK_NONE) begin
                  post_in      = 1'b1;
                  post_kind_in = p_code;
                  held_in      = '0;
               end else begin
                  if (held_ff != '0) begin
                     pre_in      = 1'b1;
                     pre_kind_in = delim_code(held_ff);
                     held_in     = '0;
                  end
                  if (is_word_char) begin
                     // store and score the character against each keyword
                     ram_we = {1'b0, count_ff} < DEPTH7;
                     if (count_ff != 6'd63) begin
                        count_in = count_ff + 6'd1;
                     end
                     if (lower < "0" || lower > "9") begin
                        digits_in = 1'b0;
                     end
                     for (int k = 0; k < NUM_KEYWORDS; k++) begin
                        match_in[k] = match_ff[k] && count_ff < {3'b0, kw_len(k)} &&
                                      kw_char(k, count_ff[2:0]) == lower;
                     end
                  end else begin
                     word_in   = count_ff != '0;
                     count_in  = '0;
                     digits_in = 1'b1;
                     match_in  = '1;
                     if (d_code != TOK_NONE) begin
                        if (can_pair(b)) begin
                           held_in = b;
                        end else begin
                           post_in      = 1'b1;
                           post_kind_in = d_code;
                        end
                     end
                  end
               end
            end
         end
         ST_BUSY: begin
            priority if (pre_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{token_kind: pre_kind_ff, text_char: '0, last_of_token: 1'b1};
                  pre_in       = 1'b0;
               end
            end else if (word_ff && long_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{token_kind: TOK_TOO_LONG, text_char: '0,
                                   last_of_token: 1'b1};
                  word_in      = 1'b0;
               end
            end else if (word_ff) begin
               if (!rd_pend_ff) begin
                  ram_re     = 1'b1;
                  rd_pend_in = 1'b1;
               end else if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{token_kind: word_kind_ff, text_char: ram_rd,
                                   last_of_token: idx_next == word_len_ff};
                  rd_pend_in   = 1'b0;
                  idx_in       = idx_next;
                  if (idx_next == word_len_ff) begin
                     word_in = 1'b0;
                  end
               end
            end else if (post_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{token_kind: post_kind_ff, text_char: '0, last_of_token: 1'b1};
                  post_in      = 1'b0;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_TEXT;
         limit_ff     <= WORD_CAP;
         count_ff     <= '0;
         digits_ff    <= 1'b1;
         match_ff     <= '1;
         held_ff      <= '0;
         pre_ff       <= 1'b0;
         word_ff      <= 1'b0;
         post_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         count_ff     <= count_in;
         digits_ff    <= digits_in;
         match_ff     <= match_in;
         held_ff      <= held_in;
         pre_ff       <= pre_in;
         word_ff      <= word_in;
         post_ff      <= post_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pre_kind_ff  <= pre_kind_in;
      long_ff      <= long_in;
      word_kind_ff <= word_kind_in;
      word_len_ff  <= word_len_in;
      idx_ff       <= idx_in;
      post_kind_ff <= post_kind_in;
      rsp_data_ff  <= rsp_data_in;
   end
endmodule
